// ===== hdl/triangle_barycentric_weights_macros.svh =====
// Assertion macros for the triangle barycentric weights block.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TBW_ASSERT_IMP(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("assertion failed");
`define TBW_ASSERT_NXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define TBW_ASSERT_IMP(label, cond, expr)
`define TBW_ASSERT_NXT(label, cond, expr)
`endif
`endif

// ===== hdl/tbw_pkg.sv =====
// Package of the triangle barycentric weights block: widths, beat types, helpers.
// Used by the interfaces, the divider cell and the top level.
package tbw_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS = 16;
	localparam int CW = COORD_WIDTH;
	localparam int DF_W = CW + 1;
	localparam int DP_W = 2 * CW + 4;
	localparam int PR_W = 2 * DP_W;
	localparam int NUM_W = PR_W + 1;
	localparam int DW = NUM_W + 1;
	localparam int WT_W = 24;
	localparam int WA_W = WT_W + 3;
	localparam int SPL_L = DP_W / 2;
	localparam int SPL_H = DP_W - SPL_L;
	localparam int RW = (DW + WT_W > NUM_W + FRAC_BITS + 2) ? DW + WT_W
		: NUM_W + FRAC_BITS + 2;

	localparam logic signed [WT_W-1:0] W_MAX = {1'b0, {(WT_W-1){1'b1}}};
	localparam logic signed [WT_W-1:0] W_MIN = {1'b1, {(WT_W-1){1'b0}}};
	localparam logic [WT_W-1:0] Q_LIM = {1'b1, {(WT_W-1){1'b0}}};
	localparam logic signed [WA_W-1:0] W_ONE = WA_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic signed [CW-1:0] vert_a_x;
		logic signed [CW-1:0] vert_a_y;
		logic signed [CW-1:0] vert_a_z;
		logic signed [CW-1:0] vert_b_x;
		logic signed [CW-1:0] vert_b_y;
		logic signed [CW-1:0] vert_b_z;
		logic signed [CW-1:0] vert_c_x;
		logic signed [CW-1:0] vert_c_y;
		logic signed [CW-1:0] vert_c_z;
	} tbw_in_t;

	typedef struct packed {
		logic signed [WT_W-1:0] weight_a;
		logic signed [WT_W-1:0] weight_b;
		logic signed [WT_W-1:0] weight_c;
		logic degenerate;
		logic saturated;
	} tbw_out_t;

	// State of one division lane as it moves down the cell row.
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] dsh;
		logic [WT_W-1:0] quo;
		logic neg;
		logic ovf;
	} tbw_lane_t;

	// Four partial products of a split signed multiply.
	typedef struct packed {
		logic signed [PR_W-1:0] ll;
		logic signed [PR_W-1:0] lh;
		logic signed [PR_W-1:0] hl;
		logic signed [PR_W-1:0] hh;
	} tbw_pp_t;

	function automatic tbw_pp_t split_mul(input logic signed [DP_W-1:0] a,
		input logic signed [DP_W-1:0] b);
		tbw_pp_t r;
		logic signed [SPL_L:0] al;
		logic signed [SPL_L:0] bl;
		logic signed [SPL_H-1:0] ah;
		logic signed [SPL_H-1:0] bh;
		logic signed [DP_W+1:0] t;
		al = $signed({1'b0, a[SPL_L-1:0]});
		bl = $signed({1'b0, b[SPL_L-1:0]});
		ah = a[DP_W-1:SPL_L];
		bh = b[DP_W-1:SPL_L];
		t = al * bl;
		r.ll = PR_W'(t);
		t = al * bh;
		r.lh = PR_W'(t);
		t = ah * bl;
		r.hl = PR_W'(t);
		t = ah * bh;
		r.hh = PR_W'(t);
		return r;
	endfunction

	function automatic logic signed [PR_W-1:0] join_pp(input tbw_pp_t p);
		return p.ll + ((p.lh + p.hl) <<< SPL_L) + (p.hh <<< (2 * SPL_L));
	endfunction
endpackage

// ===== hdl/tbw_if.sv =====
// Valid/ready channel interfaces for query and result beats.
// Depends on tbw_pkg for the payload types.
interface tbw_in_if import tbw_pkg::*; ();
	logic valid;
	logic ready;
	tbw_in_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tbw_out_if import tbw_pkg::*; ();
	logic valid;
	logic ready;
	tbw_out_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/tbw_div_cell.sv =====
// One cell of the restoring divider row: settles one quotient bit per cycle while en is high.
// Depends on tbw_pkg for the lane type.
module tbw_div_cell import tbw_pkg::*; (
	input logic clk,
	input logic en,
	input tbw_lane_t d,
	output tbw_lane_t q
);
	tbw_lane_t nxt;
	tbw_lane_t lane_q;
	logic take;

	always_comb begin
		take = d.rem >= d.dsh;
		nxt = d;
		nxt.rem = take ? d.rem - d.dsh : d.rem;
		nxt.quo = {d.quo[WT_W-2:0], take};
		nxt.dsh = d.dsh >> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

	assign q = lane_q;
endmodule

// ===== hdl/triangle_barycentric_weights.sv =====
// Barycentric weights of a point against a triangle, one query beat per cycle unless a result beat waits.
// A query beat passes through seven arithmetic stages, a row of 24 divider cells
// (one quotient bit each) and the output register on its way to its result beat.
// Throughput is one beat per cycle; the whole pipeline holds while a result beat waits.
// Reset clears all valid flags; the data registers are not reset.
`include "triangle_barycentric_weights_macros.svh"
module triangle_barycentric_weights import tbw_pkg::*; (
	input logic clk,
	input logic arst_n,
	tbw_in_if.sink req,
	tbw_out_if.source rsp
);
	// Dot product slots and product pairs.
	localparam int D00 = 0;
	localparam int D01 = 1;
	localparam int D11 = 2;
	localparam int D20 = 3;
	localparam int D21 = 4;
	localparam int NV = 7 + WT_W;

	// The pipeline advances whenever the output register is free or drained.
	logic en;
	logic [NV-1:0] vld_q;
	logic out_vld_q;
	tbw_out_t out_q;

	assign en = !out_vld_q || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = out_vld_q;
	assign rsp.payload = out_q;

	logic signed [CW-1:0] pa[3], pb[3], pc[3], pp[3];
	always_comb begin
		pp[0] = req.payload.point_x;
		pp[1] = req.payload.point_y;
		pp[2] = req.payload.point_z;
		pa[0] = req.payload.vert_a_x;
		pa[1] = req.payload.vert_a_y;
		pa[2] = req.payload.vert_a_z;
		pb[0] = req.payload.vert_b_x;
		pb[1] = req.payload.vert_b_y;
		pb[2] = req.payload.vert_b_z;
		pc[0] = req.payload.vert_c_x;
		pc[1] = req.payload.vert_c_y;
		pc[2] = req.payload.vert_c_z;
	end

	// Stage 1: edge vectors from vertex A.
	logic signed [DF_W-1:0] v0_s1[3], v1_s1[3], v2_s1[3];
	// Stage 2: the fifteen coordinate products.
	logic signed [2*DF_W-1:0] prd_s2[5][3];
	// Stage 3: the five dot products.
	logic signed [DP_W-1:0] dot_s3[5];
	// Stage 4: partial products of the six wide multiplies.
	tbw_pp_t pp_s4[6];
	// Stage 5: the six wide products.
	logic signed [PR_W-1:0] wp_s5[6];
	// Stage 6: Gram determinant and the two numerators.
	logic signed [NUM_W-1:0] det_s6, nb_s6, nc_s6;
	// Stage 7: divider lanes set up for the cell row.
	tbw_lane_t lane_b_s7, lane_c_s7;
	tbw_lane_t lane_b[WT_W+1];
	tbw_lane_t lane_c[WT_W+1];
	logic dgn_q[WT_W+1];

	// The rounded ratio is floor((2^(F+1)*|num| + det) / (2*det)). A quotient
	// that would need more than WT_W bits is flagged up front as an overflow,
	// so the cells only ever produce WT_W bits.
	function automatic tbw_lane_t make_lane(input logic signed [NUM_W-1:0] num,
		input logic signed [NUM_W-1:0] det);
		tbw_lane_t l;
		logic [NUM_W-1:0] mag;
		logic [RW-1:0] nval;
		logic [RW-1:0] den;
		mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		nval = (RW'(mag) << (FRAC_BITS + 1)) + RW'($unsigned(det));
		den = RW'($unsigned(det)) << 1;
		l.rem = nval;
		l.dsh = den << (WT_W - 1);
		l.quo = '0;
		l.neg = num[NUM_W-1];
		l.ovf = nval >= (den << WT_W);
		return l;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				v0_s1[k] <= {pb[k][CW-1], pb[k]} - {pa[k][CW-1], pa[k]};
				v1_s1[k] <= {pc[k][CW-1], pc[k]} - {pa[k][CW-1], pa[k]};
				v2_s1[k] <= {pp[k][CW-1], pp[k]} - {pa[k][CW-1], pa[k]};
				prd_s2[D00][k] <= v0_s1[k] * v0_s1[k];
				prd_s2[D01][k] <= v0_s1[k] * v1_s1[k];
				prd_s2[D11][k] <= v1_s1[k] * v1_s1[k];
				prd_s2[D20][k] <= v2_s1[k] * v0_s1[k];
				prd_s2[D21][k] <= v2_s1[k] * v1_s1[k];
			end
			for (int j = 0; j < 5; j++) begin
				dot_s3[j] <= DP_W'(prd_s2[j][0]) + DP_W'(prd_s2[j][1])
					+ DP_W'(prd_s2[j][2]);
			end
			pp_s4[0] <= split_mul(dot_s3[D00], dot_s3[D11]);
			pp_s4[1] <= split_mul(dot_s3[D01], dot_s3[D01]);
			pp_s4[2] <= split_mul(dot_s3[D11], dot_s3[D20]);
			pp_s4[3] <= split_mul(dot_s3[D01], dot_s3[D21]);
			pp_s4[4] <= split_mul(dot_s3[D00], dot_s3[D21]);
			pp_s4[5] <= split_mul(dot_s3[D01], dot_s3[D20]);
			for (int j = 0; j < 6; j++) begin
				wp_s5[j] <= join_pp(pp_s4[j]);
			end
			det_s6 <= NUM_W'(wp_s5[0]) - NUM_W'(wp_s5[1]);
			nb_s6 <= NUM_W'(wp_s5[2]) - NUM_W'(wp_s5[3]);
			nc_s6 <= NUM_W'(wp_s5[4]) - NUM_W'(wp_s5[5]);
			lane_b_s7 <= make_lane(nb_s6, det_s6);
			lane_c_s7 <= make_lane(nc_s6, det_s6);
			dgn_q[0] <= det_s6 == '0;
			for (int i = 0; i < WT_W; i++) begin
				dgn_q[i+1] <= dgn_q[i];
			end
		end
	end

	assign lane_b[0] = lane_b_s7;
	assign lane_c[0] = lane_c_s7;

	for (genvar i = 0; i < WT_W; i++) begin : g_cell
		tbw_div_cell u_cell_b (.clk(clk), .en(en), .d(lane_b[i]), .q(lane_b[i+1]));
		tbw_div_cell u_cell_c (.clk(clk), .en(en), .d(lane_c[i]), .q(lane_c[i+1]));
	end

	// Saturating signed weight from a finished lane.
	function automatic logic [WT_W:0] lane_weight(input tbw_lane_t l);
		logic sat;
		logic signed [WT_W-1:0] w;
		sat = l.ovf || (l.quo > Q_LIM) || (!l.neg && l.quo == Q_LIM);
		if (sat) begin
			w = l.neg ? W_MIN : W_MAX;
		end else begin
			w = l.neg ? -$signed(l.quo) : $signed(l.quo);
		end
		return {sat, w};
	endfunction

	logic [WT_W:0] wb_r, wc_r;
	logic signed [WT_W-1:0] wb, wc, wa;
	logic signed [WA_W-1:0] wa_full;
	logic sat_a;
	tbw_out_t res;

	always_comb begin
		wb_r = lane_weight(lane_b[WT_W]);
		wc_r = lane_weight(lane_c[WT_W]);
		wb = wb_r[WT_W-1:0];
		wc = wc_r[WT_W-1:0];
		wa_full = W_ONE - WA_W'(wb) - WA_W'(wc);
		sat_a = 1'b0;
		if (wa_full > WA_W'(W_MAX)) begin
			wa = W_MAX;
			sat_a = 1'b1;
		end else if (wa_full < WA_W'(W_MIN)) begin
			wa = W_MIN;
			sat_a = 1'b1;
		end else begin
			wa = wa_full[WT_W-1:0];
		end
		// A zero determinant overrides everything the divider produced.
		if (dgn_q[WT_W]) begin
			res.weight_a = '0;
			res.weight_b = '0;
			res.weight_c = '0;
			res.degenerate = 1'b1;
			res.saturated = 1'b0;
		end else begin
			res.weight_a = wa;
			res.weight_b = wb;
			res.weight_c = wc;
			res.degenerate = 1'b0;
			res.saturated = wb_r[WT_W] || wc_r[WT_W] || sat_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], req.valid};
			out_vld_q <= vld_q[NV-1];
		end
	end

	// Unclamped weights always add up to exactly one.
	logic signed [WA_W-1:0] wsum_chk;
	assign wsum_chk = WA_W'(out_q.weight_a) + WA_W'(out_q.weight_b)
		+ WA_W'(out_q.weight_c);

	`TBW_ASSERT_IMP(a_degen_zero, out_vld_q && out_q.degenerate, out_q.weight_a == '0 && out_q.weight_b == '0 && out_q.weight_c == '0 && !out_q.saturated)
	`TBW_ASSERT_IMP(a_sum_one, out_vld_q && !out_q.degenerate && !out_q.saturated, wsum_chk == W_ONE)
	`TBW_ASSERT_NXT(a_stall_freeze, !en, $stable(vld_q) && out_vld_q)
endmodule
